[sv/dlts_pkg.sv]
package dlts_pkg;

  localparam int DEF_TASK_SLOTS = 16;
  localparam int MAX_OUT        = 16;

  localparam logic [1:0] REQ_ADD      = 2'd0;
  localparam logic [1:0] REQ_DELETE   = 2'd1;
  localparam logic [1:0] REQ_TICK     = 2'd2;
  localparam logic [1:0] REQ_DISPATCH = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_BAD_ID   = 2'd2;
  localparam logic [1:0] ST_NO_READY = 2'd3;

  localparam logic [4:0] DUE_MAX = 5'd31;

endpackage

[sv/delta_list_task_scheduler_unit.sv]
// An add walks the delta list one entry at a time to its place, a delete walks it to
// unlink the slot, a tick decrements the head delta and pops every head that reaches zero,
// and a dispatch scans the slots up to the last ready one, walking the list again to
// re-insert each periodic slot. One request is in work at a time; in_ready is
// high only while the sequencer is idle, and a result held by out_ready adds its stall.
// The single delta compare/subtract unit sets the rate. Sync active-low reset empties all.
module delta_list_task_scheduler_unit import dlts_pkg::*; #(
  parameter int TASK_SLOTS = DEF_TASK_SLOTS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_req_type,
  input  logic [31:0] in_delay,
  input  logic [31:0] in_period,
  input  logic [3:0]  in_task_id,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  out_slot_id,
  output logic [1:0]  out_status,
  output logic [4:0]  out_due_count,
  output logic        out_last
);

  localparam int IW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam int PW = $clog2(TASK_SLOTS + 1);
  localparam int CW = $clog2(TASK_SLOTS + 1);
  localparam logic [PW-1:0] NULL_PTR = PW'(TASK_SLOTS);
  localparam logic [IW-1:0] LAST_IDX = IW'(TASK_SLOTS - 1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_EMIT  = 4'd1;
  localparam logic [3:0] S_LHEAD = 4'd2;
  localparam logic [3:0] S_LWALK = 4'd3;
  localparam logic [3:0] S_DLOAD = 4'd4;
  localparam logic [3:0] S_UWALK = 4'd5;
  localparam logic [3:0] S_TDEC  = 4'd6;
  localparam logic [3:0] S_TPOP  = 4'd7;
  localparam logic [3:0] S_DSCAN = 4'd8;

  logic [3:0]            state_r;
  logic [TASK_SLOTS-1:0] active_r, ready_r;
  logic [31:0]           delta_r  [TASK_SLOTS];
  logic [31:0]           period_r [TASK_SLOTS];
  logic [PW-1:0]         next_r   [TASK_SLOTS];
  logic [PW-1:0]         head_r;

  logic [IW-1:0] sl_r;      // slot being linked or unlinked
  logic [31:0]   d_r;       // remaining delay during a walk
  logic [PW-1:0] cur_r, prev_r;
  logic [IW-1:0] idx_r;     // dispatch scan position
  logic [4:0]    k_r;       // results emitted by this dispatch
  logic          disp_r, dlast_r;
  logic [CW-1:0] due_r;

  logic [3:0]  res_slot_r;
  logic [1:0]  res_status_r;
  logic [4:0]  res_due_r;

  logic        out_valid_r, out_last_r;
  logic [3:0]  out_slot_r;
  logic [1:0]  out_status_r;
  logic [4:0]  out_due_r;

  logic out_free;
  assign out_free = !out_valid_r || out_ready;

  // A new result is loaded into the output register this cycle.
  logic out_load;
  assign out_load = out_free &&
                    ((state_r == S_EMIT) || (state_r == S_DSCAN && ready_r[idx_r]));

  // Single read port on the delta and next arrays, address chosen by state.
  logic [PW-1:0] naddr, nx, daddr;
  logic [31:0]   delta_rd;
  always_comb begin
    naddr = cur_r;
    if (state_r == S_TPOP) naddr = head_r;
  end
  assign nx = next_r[naddr[IW-1:0]];

  always_comb begin
    unique case (state_r)
      S_LWALK, S_UWALK: daddr = nx;
      S_DLOAD:          daddr = {{(PW-IW){1'b0}}, sl_r};
      default:          daddr = head_r;
    endcase
  end
  assign delta_rd = delta_r[daddr[IW-1:0]];

  // Shared compare/subtract unit.
  logic [32:0] diff;
  logic        d_lt;
  assign diff = {1'b0, d_r} - {1'b0, delta_rd};
  assign d_lt = diff[32];

  logic [IW-1:0] free_idx;
  always_comb begin
    free_idx = '0;
    for (int j = TASK_SLOTS - 1; j >= 0; j--) begin
      if (!active_r[j]) free_idx = IW'(j);
    end
  end

  logic [TASK_SLOTS-1:0] above_mask;
  always_comb begin
    for (int j = 0; j < TASK_SLOTS; j++) begin
      above_mask[j] = (IW'(j) > idx_r);
    end
  end

  logic [5:0] due_ext;
  assign due_ext = 6'(due_r);

  logic bad_id;
  assign bad_id = (6'(in_task_id) >= 6'(TASK_SLOTS)) ||
                  !active_r[in_task_id[IW-1:0]];

  assign in_ready = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      active_r    <= '0;
      ready_r     <= '0;
      head_r      <= NULL_PTR;
      out_valid_r <= 1'b0;
      for (int j = 0; j < TASK_SLOTS; j++) begin
        delta_r[j]  <= '0;
        period_r[j] <= '0;
        next_r[j]   <= NULL_PTR;
      end
    end else begin
      if (out_valid_r && out_ready && !out_load) out_valid_r <= 1'b0;

      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            disp_r <= 1'b0;
            unique case (in_req_type)
              REQ_ADD: begin
                if (&active_r) begin
                  res_slot_r   <= '0;
                  res_status_r <= ST_FULL;
                  res_due_r    <= '0;
                  state_r      <= S_EMIT;
                end else begin
                  active_r[free_idx] <= 1'b1;
                  ready_r[free_idx]  <= 1'b0;
                  delta_r[free_idx]  <= in_delay;
                  period_r[free_idx] <= in_period;
                  next_r[free_idx]   <= NULL_PTR;
                  sl_r               <= free_idx;
                  d_r                <= in_delay;
                  state_r            <= S_LHEAD;
                end
              end
              REQ_DELETE: begin
                res_slot_r <= in_task_id;
                res_due_r  <= '0;
                if (bad_id) begin
                  res_status_r <= ST_BAD_ID;
                  state_r      <= S_EMIT;
                end else if (ready_r[in_task_id[IW-1:0]]) begin
                  // A ready slot is already out of the list.
                  active_r[in_task_id[IW-1:0]] <= 1'b0;
                  ready_r[in_task_id[IW-1:0]]  <= 1'b0;
                  delta_r[in_task_id[IW-1:0]]  <= '0;
                  period_r[in_task_id[IW-1:0]] <= '0;
                  next_r[in_task_id[IW-1:0]]   <= NULL_PTR;
                  res_status_r <= ST_OK;
                  state_r      <= S_EMIT;
                end else begin
                  sl_r    <= in_task_id[IW-1:0];
                  state_r <= S_DLOAD;
                end
              end
              REQ_TICK: begin
                res_slot_r   <= '0;
                res_status_r <= ST_OK;
                res_due_r    <= '0;
                due_r        <= '0;
                state_r      <= (head_r == NULL_PTR) ? S_EMIT : S_TDEC;
              end
              REQ_DISPATCH: begin
                res_slot_r   <= '0;
                res_status_r <= ST_NO_READY;
                res_due_r    <= '0;
                idx_r        <= '0;
                k_r          <= '0;
                disp_r       <= 1'b1;
                state_r      <= (ready_r == '0) ? S_EMIT : S_DSCAN;
              end
              default: state_r <= S_IDLE;
            endcase
          end
        end

        S_EMIT: begin
          if (out_free) begin
            out_valid_r  <= 1'b1;
            out_slot_r   <= res_slot_r;
            out_status_r <= res_status_r;
            out_due_r    <= res_due_r;
            out_last_r   <= 1'b1;
            state_r      <= S_IDLE;
          end
        end

        S_LHEAD: begin
          if (head_r == NULL_PTR || d_lt) begin
            if (head_r != NULL_PTR) delta_r[head_r[IW-1:0]] <= delta_rd - d_r;
            next_r[sl_r] <= head_r;
            head_r       <= {{(PW-IW){1'b0}}, sl_r};
            if (disp_r) begin
              state_r <= (dlast_r || idx_r == LAST_IDX) ? S_IDLE : S_DSCAN;
              idx_r   <= idx_r + 1'b1;
            end else begin
              res_slot_r   <= 4'(sl_r);
              res_status_r <= ST_OK;
              res_due_r    <= '0;
              state_r      <= S_EMIT;
            end
          end else begin
            d_r     <= diff[31:0];
            cur_r   <= head_r;
            state_r <= S_LWALK;
          end
        end

        S_LWALK: begin
          if (nx == NULL_PTR || d_lt) begin
            if (nx != NULL_PTR) delta_r[nx[IW-1:0]] <= delta_rd - d_r;
            delta_r[sl_r]          <= d_r;
            next_r[sl_r]           <= nx;
            next_r[cur_r[IW-1:0]]  <= {{(PW-IW){1'b0}}, sl_r};
            if (disp_r) begin
              state_r <= (dlast_r || idx_r == LAST_IDX) ? S_IDLE : S_DSCAN;
              idx_r   <= idx_r + 1'b1;
            end else begin
              res_slot_r   <= 4'(sl_r);
              res_status_r <= ST_OK;
              res_due_r    <= '0;
              state_r      <= S_EMIT;
            end
          end else begin
            d_r   <= diff[31:0];
            cur_r <= nx;
          end
        end

        S_DLOAD: begin
          d_r     <= delta_rd;
          cur_r   <= head_r;
          prev_r  <= NULL_PTR;
          state_r <= S_UWALK;
        end

        S_UWALK: begin
          if (cur_r == NULL_PTR || cur_r[IW-1:0] == sl_r) begin
            if (cur_r != NULL_PTR) begin
              if (prev_r == NULL_PTR) head_r <= nx;
              else next_r[prev_r[IW-1:0]] <= nx;
              if (nx != NULL_PTR) delta_r[nx[IW-1:0]] <= delta_rd + d_r;
            end
            active_r[sl_r] <= 1'b0;
            ready_r[sl_r]  <= 1'b0;
            delta_r[sl_r]  <= '0;
            period_r[sl_r] <= '0;
            next_r[sl_r]   <= NULL_PTR;
            res_status_r   <= ST_OK;
            state_r        <= S_EMIT;
          end else begin
            prev_r <= cur_r;
            cur_r  <= nx;
          end
        end

        S_TDEC: begin
          if (delta_rd != '0) delta_r[head_r[IW-1:0]] <= delta_rd - 32'd1;
          state_r <= S_TPOP;
        end

        S_TPOP: begin
          if (head_r == NULL_PTR || delta_rd != '0) begin
            res_due_r <= (due_ext > 6'(DUE_MAX)) ? DUE_MAX : due_ext[4:0];
            state_r   <= S_EMIT;
          end else begin
            ready_r[head_r[IW-1:0]] <= 1'b1;
            next_r[head_r[IW-1:0]]  <= NULL_PTR;
            head_r                  <= nx;
            due_r                   <= due_r + 1'b1;
          end
        end

        S_DSCAN: begin
          if (ready_r[idx_r]) begin
            if (out_free) begin
              out_valid_r  <= 1'b1;
              out_slot_r   <= 4'(idx_r);
              out_status_r <= ST_OK;
              out_due_r    <= '0;
              out_last_r   <= (k_r == 5'(MAX_OUT - 1)) || !(|(ready_r & above_mask));
              dlast_r      <= (k_r == 5'(MAX_OUT - 1)) || !(|(ready_r & above_mask));
              k_r          <= k_r + 5'd1;
              ready_r[idx_r] <= 1'b0;
              next_r[idx_r]  <= NULL_PTR;
              if (period_r[idx_r] != '0) begin
                delta_r[idx_r] <= period_r[idx_r];
                sl_r           <= idx_r;
                d_r            <= period_r[idx_r];
                state_r        <= S_LHEAD;
              end else begin
                active_r[idx_r] <= 1'b0;
                delta_r[idx_r]  <= '0;
                idx_r           <= idx_r + 1'b1;
                state_r <= ((k_r == 5'(MAX_OUT - 1)) || !(|(ready_r & above_mask)) ||
                            idx_r == LAST_IDX) ? S_IDLE : S_DSCAN;
              end
            end
          end else begin
            idx_r   <= idx_r + 1'b1;
            state_r <= (idx_r == LAST_IDX) ? S_IDLE : S_DSCAN;
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid     = out_valid_r;
  assign out_slot_id   = out_slot_r;
  assign out_status    = out_status_r;
  assign out_due_count = out_due_r;
  assign out_last      = out_last_r;

endmodule

[sv/dlts_checker.sv]
module dlts_checker import dlts_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [3:0]  out_slot_id,
  input logic [1:0]  out_status,
  input logic [4:0]  out_due_count,
  input logic        out_last
);

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_slot_id) &&
    $stable(out_status) && $stable(out_due_count) && $stable(out_last))
    else $error("result changed while stalled");

  // After taking a request the block is not ready in the next cycle.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted back to back");

  // Only a tick reports a due count, and it ends its request.
  a_due: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_due_count != 5'd0 |-> out_status == ST_OK && out_last &&
    out_slot_id == 4'd0)
    else $error("due count on a non-tick result");

  // A full pool or an empty dispatch gives a single result with slot zero.
  a_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_FULL || out_status == ST_NO_READY) |->
    out_last && out_slot_id == 4'd0)
    else $error("bad full or empty-dispatch result");

endmodule

bind delta_list_task_scheduler_unit dlts_checker u_dlts_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_slot_id(out_slot_id),
  .out_status(out_status), .out_due_count(out_due_count), .out_last(out_last)
);
